@@ hdl/rse_pkg.sv @@
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon encoder.
`timescale 1ns / 1ps
package rse_pkg;

  localparam int MAX_PARITY = 32;
  localparam int CW = $clog2(MAX_PARITY + 1);

  localparam logic [5:0] PARITY_COUNT_RST = 6'd10;
  localparam logic [7:0] FIELD_POLY_RST = 8'd29;
  localparam logic [7:0] ALPHA = 8'd2;

  typedef enum logic [0:0] {
    REG_PARITY_COUNT = 1'b0,
    REG_FIELD_POLY   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       is_parity;
    logic       last_symbol;
  } code_t;

  typedef logic [MAX_PARITY:0][7:0] gen_t;
  typedef logic [MAX_PARITY-1:0][7:0] par_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic room;
  } ctrl_t;

  localparam gen_t GEN_SEED = gen_t'(1);

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] poly);
    logic [7:0] x;
    logic [7:0] acc;
    acc = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? poly : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [CW-1:0] eff_count(input logic [5:0] pc);
    logic [CW-1:0] n;
    if (pc == 6'd0) begin
      n = CW'(1);
    end else if (7'(pc) > 7'(MAX_PARITY)) begin
      n = CW'(MAX_PARITY);
    end else begin
      n = CW'(pc);
    end
    return n;
  endfunction

endpackage

@@ hdl/rse_gen.sv @@
// Generator polynomial builder: multiplies in one root factor per cycle.
`timescale 1ns / 1ps
module rse_gen (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rse_pkg::CW-1:0] n,
  input  logic [7:0]             poly,
  output rse_pkg::gen_t          gen,
  output logic                   busy
);

  rse_pkg::gen_t         gen_next;
  logic [7:0]            root;
  logic [7:0]            root_next;
  logic [rse_pkg::CW-1:0] step;

  always_comb begin
    gen_next = gen;
    for (int j = 1; j <= rse_pkg::MAX_PARITY; j++) begin
      gen_next[j] = gen[j] ^ rse_pkg::gmul(root, gen[j-1], poly);
    end
    root_next = rse_pkg::gmul(root, rse_pkg::ALPHA, poly);
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      gen  <= rse_pkg::GEN_SEED;
      root <= 8'd1;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      gen  <= gen_next;
      root <= root_next;
      step <= step + rse_pkg::CW'(1);
      if (step == n - rse_pkg::CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/rse_lfsr.sv @@
// Parity LFSR dividing by the generator, with remainder drain after the last byte.
`timescale 1ns / 1ps
module rse_lfsr (
  input  logic                   clk,
  input  logic                   rst,
  input  rse_pkg::ctrl_t         ctrl,
  input  rse_pkg::msg_t          msg,
  input  rse_pkg::gen_t          gen,
  input  logic [rse_pkg::CW-1:0] n,
  input  logic [7:0]             poly,
  output logic                   push,
  output rse_pkg::code_t         item,
  output logic                   emitting
);

  rse_pkg::par_t          regs;
  rse_pkg::par_t          regs_upd;
  logic [7:0]             fb;
  logic [rse_pkg::CW-1:0] emit_index;
  logic                   emit_go;
  logic                   emit_end;

  always_comb begin
    fb = msg.data_byte ^ regs[0];
    for (int j = 0; j < rse_pkg::MAX_PARITY - 1; j++) begin
      regs_upd[j] = regs[j+1] ^ rse_pkg::gmul(fb, gen[j+1], poly);
    end
    regs_upd[rse_pkg::MAX_PARITY-1] =
      rse_pkg::gmul(fb, gen[rse_pkg::MAX_PARITY], poly);
  end

  assign emit_go  = emitting && ctrl.room;
  assign emit_end = (emit_index == n - rse_pkg::CW'(1));
  assign push     = ctrl.accept || emit_go;

  always_comb begin
    if (emitting) begin
      item.code_byte   = regs[0];
      item.is_parity   = 1'b1;
      item.last_symbol = emit_end;
    end else begin
      item.code_byte   = msg.data_byte;
      item.is_parity   = 1'b0;
      item.last_symbol = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      regs       <= '0;
      emitting   <= 1'b0;
      emit_index <= '0;
    end else if (ctrl.accept) begin
      regs <= regs_upd;
      if (msg.end_of_message) begin
        emitting   <= 1'b1;
        emit_index <= '0;
      end
    end else if (emit_go) begin
      regs       <= rse_pkg::par_t'(regs >> 8);
      emit_index <= emit_index + rse_pkg::CW'(1);
      if (emit_end) begin
        emitting   <= 1'b0;
        emit_index <= '0;
      end
    end
  end

  a_no_accept_while_draining: assert property (@(posedge clk) disable iff (rst)
    ctrl.accept |-> !emitting)
    else $error("request accepted during parity drain");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    emitting |-> (emit_index < n))
    else $error("parity index beyond parity count");

  a_clear_after_drain: assert property (@(posedge clk) disable iff (rst)
    (emit_go && emit_end) |=> (regs == '0))
    else $error("parity registers not clear after drain");

endmodule

@@ hdl/rse_out_queue.sv @@
// Two-entry output queue decoupling result stall from request acceptance.
`timescale 1ns / 1ps
module rse_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rse_pkg::code_t push_data,
  output logic           full,
  output logic           valid,
  input  logic           stall,
  output rse_pkg::code_t data
);

  rse_pkg::code_t mem [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           pop;
  logic           do_push;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign pop     = valid && !stall;
  assign do_push = push && !full;
  assign data    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, pop};
    end
  end

endmodule

@@ hdl/reed_solomon_systematic_encoder_top.sv @@
// Top level of the systematic GF(256) Reed-Solomon encoder with register port.
`timescale 1ns / 1ps
// Message bytes are taken one per cycle unless stalled and echoed; the parity
// register bank updates in the same cycle. After the byte marked
// end_of_message msg_stall stays high while n parity symbols (n = parity_count
// clamped to 1..32) drain from the parity shift register one symbol per cycle
// unless the queue is full, highest degree first. After reset and after every
// register write the generator is rebuilt one root factor per cycle with
// msg_stall high; a write also drops any message in progress. A two-entry
// output queue lets requests continue while a result waits on code_stall.
module reed_solomon_systematic_encoder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           msg_valid,
  output logic           msg_stall,
  input  rse_pkg::msg_t  msg,
  output logic           code_valid,
  input  logic           code_stall,
  output rse_pkg::code_t code,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [5:0]             parity_count;
  logic [7:0]             field_poly_low;
  logic [rse_pkg::CW-1:0] n_eff;
  logic                   wr;
  rse_pkg::reg_idx_t      idx;
  rse_pkg::gen_t          gen;
  logic                   gen_busy;
  logic                   emitting;
  logic                   q_full;
  logic                   push;
  rse_pkg::code_t         item;
  rse_pkg::ctrl_t         ctrl;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = rse_pkg::reg_idx_t'(paddr[2]);
  assign n_eff  = rse_pkg::eff_count(parity_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_count   <= rse_pkg::PARITY_COUNT_RST;
      field_poly_low <= rse_pkg::FIELD_POLY_RST;
    end else if (wr) begin
      case (idx)
        rse_pkg::REG_PARITY_COUNT: parity_count   <= pwdata[5:0];
        rse_pkg::REG_FIELD_POLY:   field_poly_low <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rse_pkg::REG_PARITY_COUNT: prdata = {26'd0, parity_count};
      rse_pkg::REG_FIELD_POLY:   prdata = {24'd0, field_poly_low};
      default:                   prdata = '0;
    endcase
  end

  assign msg_stall   = gen_busy || emitting || q_full;
  assign ctrl.accept = msg_valid && !msg_stall;
  assign ctrl.clear  = wr;
  assign ctrl.room   = !q_full;

  rse_gen u_gen (
    .clk   (clk),
    .rst   (rst),
    .start (wr),
    .n     (n_eff),
    .poly  (field_poly_low),
    .gen   (gen),
    .busy  (gen_busy)
  );

  rse_lfsr u_lfsr (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .msg      (msg),
    .gen      (gen),
    .n        (n_eff),
    .poly     (field_poly_low),
    .push     (push),
    .item     (item),
    .emitting (emitting)
  );

  rse_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (item),
    .full      (q_full),
    .valid     (code_valid),
    .stall     (code_stall),
    .data      (code)
  );

endmodule
